@@ sv/selective_repeat_receiver_defines.svh @@
// Assertion macros for the selective-repeat receiver.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SRR_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SRR_ASSERT(label, clk, rst_n, prop)
`define SRR_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ sv/srr_pkg.sv @@
// Package: beat types, codes and byte-sum helper for the selective-repeat receiver.
package srr_pkg;
    typedef struct packed {
        logic signed [31:0] seq_number;
        logic signed [31:0] ack_number;
        logic signed [31:0] check_value;
        logic [63:0]        payload_word;
        logic [1:0]         word_position;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] out_seq_number;
        logic signed [31:0] out_ack_number;
        logic signed [31:0] out_check_value;
        logic [63:0]        data_word;
        logic [1:0]         out_word_position;
        logic               last_result;
    } t_out_beat;

    // Receive window size, a power of two so the slot index is a bit slice
    localparam int WINDOW = 8;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    localparam logic [1:0] POS_W0 = 2'd0;
    localparam logic [1:0] POS_W1 = 2'd1;
    localparam logic [1:0] POS_W2 = 2'd2;
    localparam logic [1:0] POS_BAD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_DROP,
        ST_LOOK,
        ST_CHECK,
        ST_DELIVER
    } t_state;

    // Sum of the low nbytes of a word, bytes taken as signed
    function automatic logic [31:0] byte_sum(input logic [63:0] w, input logic [3:0] nbytes);
        logic [31:0] s;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < int'(nbytes)) begin
                s = s + {{24{w[8*k+7]}}, w[8*k +: 8]};
            end
        end
        return s;
    endfunction
endpackage

@@ sv/selective_repeat_receiver.sv @@
// Top level: selective-repeat receiver with slot memory and delivery sequencer.
//
// Input channel: one beat per packet word (positions 0, 1, 2); valid/stall.
// Output channel: result beats (ack, delivered data word, drop); valid/stall.
// Words 0 and 1 are absorbed and give no result. Word 2 checks the
// checksum; on a match an ack is emitted, then a drop report if the packet
// lies beyond the window; a packet in the window is stored, one below the
// next expected number is neither. Delivery then walks the slot memory from
// the next expected number: each slot takes a read state (LOOK), a compare
// state (CHECK) and three output beats. The sequencer handles one item at a
// time, and the registered memory read sets the overhead.
// The newest result waits in a hold register until it is known whether it is
// the last one, then moves to the output register, which keeps a beat while
// the downstream side stalls; nothing is lost. Input stall is high while busy.
// Reset (synchronous, active low) clears the expected number, the slot
// valid bits and the running sum; the slot memory needs no clearing pass.
// The last beat caused by an input has last_result set.
module selective_repeat_receiver import srr_pkg::*; #(
    parameter int SEQ_LIMIT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);
`include "selective_repeat_receiver_defines.svh"
    localparam int NE_W = $clog2(SEQ_LIMIT + 1);
    localparam int SL_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_state r_state, n_state;
    logic [NE_W-1:0]   r_next, n_next;
    logic [WINDOW-1:0] r_filled, n_filled;
    logic [31:0]       r_sum;
    logic [63:0]       r_w0, r_w1;
    t_in_beat          r_pkt;
    logic [1:0]        r_widx, n_widx;
    logic              r_oval, n_oval;
    t_out_beat         r_out, n_out;
    logic              r_hval, n_hval;
    t_out_beat         r_hold, n_hold;

    logic [191:0]      rd_words;
    logic [NE_W-1:0]   rd_seq;
    logic              acc, out_free, can_emit;
    logic [31:0]       chk;
    logic              in_win, above;
    logic [SL_W-1:0]   nslot, pslot;
    logic              store_we;
    logic [NE_W-1:0]   pseq;

    assign acc      = i_valid && !o_stall;
    assign out_free = !r_oval || !i_stall;
    // A new result may be held once the held one can move on
    assign can_emit = !r_hval || out_free;
    assign o_stall  = (r_state != ST_IDLE) || !out_free;
    assign o_valid  = r_oval;
    assign o_data   = r_out;

    // Checksum of the completing word
    assign chk = r_sum + byte_sum({32'd0, i_data.payload_word[31:0]}, 4'd4)
               + i_data.seq_number + i_data.ack_number;

    // Window test on the held packet
    assign pseq   = r_pkt.seq_number[NE_W-1:0];
    assign above  = !r_pkt.seq_number[31] && ({1'b0, r_pkt.seq_number} >= 33'(r_next));
    assign in_win = above && (r_pkt.seq_number < 32'(SEQ_LIMIT))
                  && (32'(r_pkt.seq_number) - 32'(r_next) < 32'(WINDOW));
    assign nslot  = SL_W'(r_next % WINDOW);
    assign pslot  = SL_W'(pseq % WINDOW);
    assign store_we = (r_state == ST_ACK) && can_emit && in_win;

    srr_slot_mem #(.SLOTS(WINDOW), .SEQ_W(NE_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_wslot (pslot),
        .i_wwords({32'd0, r_pkt.payload_word[31:0], r_w1, r_w0}),
        .i_wseq  (pseq),
        .i_rslot (nslot),
        .o_rwords(rd_words),
        .o_rseq  (rd_seq)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_data.word_position == POS_W2 && chk == i_data.check_value)
                    n_state = ST_ACK;
            end
            ST_ACK: begin
                if (can_emit) n_state = (above && !in_win) ? ST_DROP : ST_LOOK;
            end
            ST_DROP:    if (can_emit) n_state = ST_LOOK;
            ST_LOOK:    n_state = ST_CHECK;
            ST_CHECK: begin
                if (out_free) begin
                    if (r_next < NE_W'(SEQ_LIMIT) && r_filled[nslot] && rd_seq == r_next)
                        n_state = ST_DELIVER;
                    else
                        n_state = ST_IDLE;
                end
            end
            ST_DELIVER: begin
                if (can_emit && r_widx == 2'd2) n_state = ST_LOOK;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_next   = r_next;
        n_filled = r_filled;
        n_widx   = r_widx;
        n_oval   = r_oval && i_stall;
        n_out    = r_out;
        n_hval   = r_hval;
        n_hold   = r_hold;
        case (r_state)
            ST_ACK: begin
                if (can_emit) begin
                    if (r_hval) begin
                        n_oval = 1'b1;
                        n_out  = r_hold;
                    end
                    n_hval = 1'b1;
                    n_hold = '{KIND_ACK, r_pkt.seq_number, r_pkt.ack_number,
                               r_pkt.check_value, 64'd0, POS_W0, 1'b0};
                    if (in_win) n_filled[pslot] = 1'b1;
                end
            end
            ST_DROP: begin
                if (can_emit) begin
                    if (r_hval) begin
                        n_oval = 1'b1;
                        n_out  = r_hold;
                    end
                    n_hval = 1'b1;
                    n_hold = '{KIND_DROP, r_pkt.seq_number, 32'sd0, 32'sd0,
                               64'd0, POS_W0, 1'b0};
                end
            end
            ST_CHECK: begin
                n_widx = 2'd0;
                if (out_free && !(r_next < NE_W'(SEQ_LIMIT) && r_filled[nslot]
                                  && rd_seq == r_next)) begin
                    // Nothing more to deliver: the held beat is the final one
                    n_oval = 1'b1;
                    n_out  = r_hold;
                    n_out.last_result = 1'b1;
                    n_hval = 1'b0;
                end
            end
            ST_DELIVER: begin
                if (can_emit) begin
                    if (r_hval) begin
                        n_oval = 1'b1;
                        n_out  = r_hold;
                    end
                    n_hval = 1'b1;
                    n_hold = '{KIND_DATA, 32'(r_next), 32'sd0, 32'sd0,
                               rd_words[64*r_widx +: 64], r_widx, 1'b0};
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd2) begin
                        n_filled[nslot] = 1'b0;
                        n_next = r_next + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_next   <= '0;
            r_filled <= '0;
            r_sum    <= '0;
            r_oval   <= 1'b0;
            r_hval   <= 1'b0;
            r_widx   <= '0;
        end else begin
            r_state  <= n_state;
            r_next   <= n_next;
            r_filled <= n_filled;
            r_oval   <= n_oval;
            r_hval   <= n_hval;
            r_widx   <= n_widx;
            if (acc) begin
                case (i_data.word_position)
                    POS_W0:  r_sum <= byte_sum(i_data.payload_word, 4'd8);
                    POS_W1:  r_sum <= r_sum + byte_sum(i_data.payload_word, 4'd8);
                    POS_W2:  r_sum <= '0;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
        if (acc && i_data.word_position == POS_W0) r_w0 <= i_data.payload_word;
        if (acc && i_data.word_position == POS_W1) r_w1 <= i_data.payload_word;
        if (acc && i_data.word_position == POS_W2) r_pkt <= i_data;
    end

    `SRR_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> o_stall)
    `SRR_ASSERT(a_next_bound, i_clk, i_rst_n, r_next <= NE_W'(SEQ_LIMIT))
    `SRR_ASSERT(a_hold_in_check, i_clk, i_rst_n, (r_state == ST_CHECK) |-> r_hval)
    `SRR_ASSERT(a_deliver_after_check, i_clk, i_rst_n, (r_state == ST_DELIVER && !$past(r_state == ST_DELIVER)) |-> $past(r_state == ST_CHECK))
endmodule

@@ sv/srr_slot_mem.sv @@
// Slot store: packet words and sequence tags, registered read port.
module srr_slot_mem import srr_pkg::*; #(
    parameter int SLOTS = 8,
    parameter int SEQ_W = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_wslot,
    input  logic [191:0]             i_wwords,
    input  logic [SEQ_W-1:0]         i_wseq,
    input  logic [$clog2(SLOTS)-1:0] i_rslot,
    output logic [191:0]             o_rwords,
    output logic [SEQ_W-1:0]         o_rseq
);
    logic [191:0]     r_words [SLOTS];
    logic [SEQ_W-1:0] r_seq   [SLOTS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_words[i_wslot] <= i_wwords;
            r_seq[i_wslot]   <= i_wseq;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rwords <= r_words[i_rslot];
        o_rseq   <= r_seq[i_rslot];
    end
endmodule
